/* sv/mtf_pkg.sv */
package mtf_pkg;

  localparam int KEY_W      = 32;
  localparam int SLOT_W     = 4;
  localparam int LEN_W      = 5;
  localparam int POS_W      = 4;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 2;

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

  // register index, byte address is index times four
  localparam logic [APB_ADDR_W-1:0] REG_LIST_LENGTH = 2'd0;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_FRONT  = 2'd2,
    CMD_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COMPARE,
    PH_UPDATE
  } phase_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic             cmp_en;
    logic             upd_en;
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

/* sv/mtf_cell.sv */
module mtf_cell
  import mtf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic             active,
  input  logic             last,
  input  logic             wr_sel,
  input  logic             hit,
  input  logic [KEY_W-1:0] left_in,
  input  logic [KEY_W-1:0] right_in,
  input  logic             before_in,
  output logic             before_out,
  output logic             first_out,
  output logic [KEY_W-1:0] entry_out
);

  logic [KEY_W-1:0] entry_r;
  logic [KEY_W-1:0] entry_nxt;
  logic             match_r;
  logic             match_nxt;

  // compare against the broadcast key, only inside the active list
  always_comb begin
    match_nxt = match_r;
    if (ctl.cmp_en) begin
      match_nxt = active && (entry_r == ctl.key);
    end
  end

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.upd_en) begin
      case (ctl.cmd)
        CMD_WRITE: begin
          if (wr_sel) entry_nxt = ctl.key;
        end
        CMD_FRONT: begin
          // cells up to and including the first match take the left neighbor
          if (hit && !before_in) entry_nxt = left_in;
        end
        CMD_BACK: begin
          // cells from the first match to the list end take the right neighbor, the last takes the key
          if (active && (before_in || match_r)) begin
            entry_nxt = last ? ctl.key : right_in;
          end
        end
        default: entry_nxt = entry_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign before_out = before_in | match_r;
  assign first_out  = match_r & ~before_in;
  assign entry_out  = entry_r;

endmodule

/* sv/move_to_front_list_top.sv */
// Self-organizing key list with move-to-front and move-to-back. Each input word
// carries a command: write stores a key at a slot, search reports the lowest
// active position holding the key, and the two move commands also pull the
// first match out and reinsert it at position 0 or at list_length-1, shifting
// the entries in between by one place. Every word returns exactly one result
// word: found plus the original position (for a write, found=1 and the slot).
// The list lives in a row of DEPTH cells, one key per cell. A word runs through
// a compare phase, in which all cells compare the key at once, and then an
// update phase, in which the first-match chain runs down the row and every
// cell in the moved span loads its neighbor; the update waits while the result
// output is stalled. A new word is taken in the same cycle the previous one
// finishes. list_length (APB offset 0x0, reset 16) sets how many cells are in
// use; values above DEPTH act as DEPTH. Entries have no reset value: read only
// cells that were written. Change list_length only while the list is idle.
module move_to_front_list_top
  import mtf_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,

  // input words
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_cmd,
  input  logic [SLOT_W-1:0]       in_slot,
  input  logic signed [KEY_W-1:0] in_key,

  // result words
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_found,
  output logic [POS_W-1:0]        out_position,

  // configuration
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [APB_ADDR_W-1:0]   cfg_paddr,
  input  logic [APB_DATA_W-1:0]   cfg_pwdata,
  output logic [APB_DATA_W-1:0]   cfg_prdata,
  output logic                    cfg_pready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // config register
  logic [LEN_W-1:0] list_length_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  // one register only, so every offset decodes to it
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      ((cfg_paddr >> 2) == REG_LIST_LENGTH);
  assign cfg_prdata = APB_DATA_W'(list_length_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_length_r <= LEN_RESET;
    end else if (cfg_wr) begin
      list_length_r <= cfg_pwdata[LEN_W-1:0];
    end
  end

  // sequencer
  phase_t phase_r;
  phase_t phase_nxt;
  logic   in_accept;
  logic   upd_fire;
  logic   cmp_en;

  // word held while it runs through compare and update
  cmd_t              cmd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [KEY_W-1:0]  key_r;

  // output register
  logic             out_valid_r;
  logic             out_found_r;
  logic [POS_W-1:0] out_position_r;
  logic             out_found_nxt;
  logic [POS_W-1:0] out_position_nxt;

  // outputs of the sequencer
  always_comb begin
    cmp_en   = 1'b0;
    upd_fire = 1'b0;
    unique case (phase_r)
      PH_IDLE:    ;
      PH_COMPARE: cmp_en = 1'b1;
      // the update commits only once the result register can take the word
      PH_UPDATE:  upd_fire = !out_valid_r || !out_stall;
      default:    ;
    endcase
  end

  // next word is taken while idle or while the current word commits
  assign in_stall  = !((phase_r == PH_IDLE) || upd_fire);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE:    if (in_accept) phase_nxt = PH_COMPARE;
      PH_COMPARE: phase_nxt = PH_UPDATE;
      PH_UPDATE: begin
        if (upd_fire) phase_nxt = in_accept ? PH_COMPARE : PH_IDLE;
      end
      default:    phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r  <= cmd_t'(in_cmd);
      slot_r <= in_slot;
      key_r  <= in_key;
    end
  end

  // cell row
  cell_ctl_t        ctl;
  logic [DEPTH-1:0] active;
  logic [DEPTH-1:0] last;
  logic [DEPTH-1:0] wr_sel;
  logic [DEPTH-1:0] first_vec;
  logic [DEPTH:0]   before_chain;
  logic [KEY_W-1:0] entry_q [DEPTH];
  logic [KEY_W-1:0] left_q  [DEPTH];
  logic [KEY_W-1:0] right_q [DEPTH];
  logic             hit;

  assign ctl.cmp_en = cmp_en;
  assign ctl.upd_en = upd_fire;
  assign ctl.cmd    = cmd_r;
  assign ctl.key    = key_r;

  assign before_chain[0] = 1'b0;
  // the chain end says whether any active cell matched
  assign hit = before_chain[DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign active[g] = (32'(list_length_r) > g);
    // last active cell; a length above DEPTH saturates to the end of the row
    if (g == DEPTH - 1) begin : g_tail
      assign last[g] = (32'(list_length_r) >= DEPTH);
    end else begin : g_body
      assign last[g] = (32'(list_length_r) == g + 1);
    end
    assign wr_sel[g] = (32'(slot_r) == g);

    // cell 0 takes the key on a move to front; on a move to back the last active cell takes it
    if (g == 0) begin : g_left_key
      assign left_q[g] = key_r;
    end else begin : g_left_nb
      assign left_q[g] = entry_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_right_key
      assign right_q[g] = key_r;
    end else begin : g_right_nb
      assign right_q[g] = entry_q[g+1];
    end

    mtf_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .active     (active[g]),
      .last       (last[g]),
      .wr_sel     (wr_sel[g]),
      .hit        (hit),
      .left_in    (left_q[g]),
      .right_in   (right_q[g]),
      .before_in  (before_chain[g]),
      .before_out (before_chain[g+1]),
      .first_out  (first_vec[g]),
      .entry_out  (entry_q[g])
    );
  end

  // encode the one-hot first match into a position
  logic [PW-1:0] pos;

  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_vec[i]) pos = pos | PW'(i);
    end
  end

  always_comb begin
    if (cmd_r == CMD_WRITE) begin
      out_found_nxt    = 1'b1;
      out_position_nxt = POS_W'(slot_r);
    end else begin
      out_found_nxt    = hit;
      out_position_nxt = POS_W'(pos);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_found_r    <= out_found_nxt;
      out_position_r <= out_position_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

`ifndef SYNTH
  // a compare cycle is always followed by the update of the same word
  a_cmp_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_COMPARE |=> phase_r == PH_UPDATE)
    else $error("compare not followed by update");

  // an accepted word starts its compare in the next cycle
  a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> phase_r == PH_COMPARE)
    else $error("accepted word did not enter compare");

  // the match chain marks at most one first match
  a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_UPDATE |-> $onehot0(first_vec))
    else $error("more than one first match");

  // a committed update always shows up in the result register
  a_upd_result: assert property (@(posedge clk) disable iff (!rst_n)
    upd_fire |=> out_valid_r)
    else $error("update committed without a result");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    upd_fire && (cmd_r != CMD_WRITE) && !hit |=> out_position_r == '0)
    else $error("miss with nonzero position");
`endif

endmodule
